[hw/rtl/psu_pkg.sv]
// Shared types and constants for the PNG scanline unfilter.
`timescale 1ns / 1ps

package psu_pkg;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 13;
  localparam int BPP_W   = 4;
  localparam int FILT_W  = 3;

  // PNG filter type codes
  localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
  localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
  localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
  localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
  localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              row_start;
    logic              first_row;
  } psu_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  row_position;
  } psu_out_t;

  // Per-beat control carried from the input stage to reconstruction
  typedef struct packed {
    logic [FILT_W-1:0] filt_mode;
    logic              prior_zero;
    logic              left_ok;
  } psu_stage_t;

  function automatic logic [BYTE_W-1:0] paeth_pick(
    input logic [BYTE_W-1:0] a,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] c
  );
    logic signed [BYTE_W+2:0] sa, sb, sc, da, db, dc;
    logic [BYTE_W-1:0]        pick;
    sa = $signed({3'b000, a});
    sb = $signed({3'b000, b});
    sc = $signed({3'b000, c});
    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) begin
      pick = a;
    end else if (db <= dc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

[hw/rtl/psu_row_mem.sv]
// Previous-row byte store: one write port, one registered read port.
`timescale 1ns / 1ps

module psu_row_mem import psu_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/psu_recon.sv]
// Reconstruction stage: prediction, add, left history and output register.
`timescale 1ns / 1ps

module psu_recon import psu_pkg::*; #(
  parameter int PIXEL_BYTES_MAX = 8,
  parameter int AW              = 13,
  parameter int PW              = (PIXEL_BYTES_MAX > 1) ? $clog2(PIXEL_BYTES_MAX) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s1_valid,
  input  psu_stage_t        s1_ctrl,
  input  logic [BYTE_W-1:0] s1_byte,
  input  logic [AW-1:0]     s1_index,
  input  logic [PW-1:0]     left_sel,
  input  logic [BYTE_W-1:0] above_raw,
  output logic              take,
  output logic [BYTE_W-1:0] result,
  output logic              out_valid,
  input  logic              out_ready,
  output psu_out_t          out_data
);

  logic [BYTE_W-1:0] hist_out   [PIXEL_BYTES_MAX];
  logic [BYTE_W-1:0] hist_above [PIXEL_BYTES_MAX];
  logic [BYTE_W-1:0] above, left, upleft, pred;
  logic [BYTE_W:0]   avg_sum;
  logic              commit;

  assign take   = !out_valid || out_ready;
  assign commit = s1_valid && take;

  always_comb begin
    above   = s1_ctrl.prior_zero ? '0 : above_raw;
    left    = s1_ctrl.left_ok ? hist_out[left_sel] : '0;
    upleft  = s1_ctrl.left_ok ? hist_above[left_sel] : '0;
    avg_sum = {1'b0, left} + {1'b0, above};
    case (s1_ctrl.filt_mode)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = above;
      FILT_AVG:   pred = avg_sum[BYTE_W:1];
      FILT_PAETH: pred = paeth_pick(left, above, upleft);
      default:    pred = '0;
    endcase
    result = s1_byte + pred;
  end

  // last PIXEL_BYTES_MAX results and their above bytes, newest at slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIXEL_BYTES_MAX; k++) begin
        hist_out[k]   <= '0;
        hist_above[k] <= '0;
      end
    end else if (commit) begin
      hist_out[0]   <= result;
      hist_above[0] <= above;
      for (int k = 1; k < PIXEL_BYTES_MAX; k++) begin
        hist_out[k]   <= hist_out[k-1];
        hist_above[k] <= hist_above[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.out_byte     <= result;
      out_data.row_position <= POS_W'(32'(s1_index));
    end
  end

endmodule

[hw/rtl/png_scanline_unfilter.sv]
// Top level of the PNG scanline unfilter.
// Path: an accepted data beat is registered in s1, then in the out register
//   when s1 commits, and is taken by the receiver from there.
// Throughput: one beat per cycle unless out stalls; row start beats yield no output.
// Stalls: out register plus one work stage; while out holds, input stays ready
//   until s1 also fills.
// Reset: control, history and bytes_per_pixel (to 1) clear; row store is not
//   cleared, the first row of an image must be flagged first_row.
`timescale 1ns / 1ps

module png_scanline_unfilter import psu_pkg::*; #(
  parameter int ROW_BYTES_MAX   = 8192,
  parameter int PIXEL_BYTES_MAX = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  psu_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output psu_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [BPP_W-1:0] cfg_data
);

  localparam int AW = $clog2(ROW_BYTES_MAX);
  localparam int CW = AW + 1;
  localparam int PW = (PIXEL_BYTES_MAX > 1) ? $clog2(PIXEL_BYTES_MAX) : 1;

  // Config: bytes per pixel, taken any time (user must write only while idle; not enforced)
  logic [BPP_W-1:0] bytes_per_pixel;
  logic [BPP_W-1:0] bpp_eff;

  // Row state
  logic [FILT_W-1:0] filt_mode;
  logic              prior_zero;
  logic [CW-1:0]     byte_index;

  // Work stage s1: beat waiting for its above byte from the row store
  logic              s1_valid;
  psu_stage_t        s1_ctrl;
  logic [BYTE_W-1:0] s1_byte;
  logic [AW-1:0]     s1_index;

  logic              s1_take;
  logic              in_fire;
  logic              data_fire;
  logic              commit;
  logic [BYTE_W-1:0] above_raw;
  logic [BYTE_W-1:0] result;
  logic [PW-1:0]     left_sel;
  psu_stage_t        stage_ctrl;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid || s1_take;
  assign in_fire   = in_valid && in_ready;
  // beats past the end of the store are swallowed
  assign data_fire = in_fire && !in_data.row_start && (byte_index < CW'(ROW_BYTES_MAX));
  assign commit    = s1_valid && s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      bytes_per_pixel <= cfg_data;
    end
  end

  // out of range bytes per pixel: 0 acts as 1, above the maximum as the maximum
  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bytes_per_pixel > BPP_W'(PIXEL_BYTES_MAX)) begin
      bpp_eff = BPP_W'(PIXEL_BYTES_MAX);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
    left_sel = PW'(bpp_eff - BPP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt_mode  <= FILT_NONE;
      prior_zero <= 1'b1;
      byte_index <= '0;
    end else if (in_fire && in_data.row_start) begin
      filt_mode  <= (in_data.in_byte <= BYTE_W'(FILT_PAETH)) ?
                    in_data.in_byte[FILT_W-1:0] : FILT_NONE;
      prior_zero <= in_data.first_row;
      byte_index <= '0;
    end else if (data_fire) begin
      byte_index <= byte_index + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      s1_ctrl.filt_mode  <= filt_mode;
      s1_ctrl.prior_zero <= prior_zero;
      s1_ctrl.left_ok    <= 1'b0;
      s1_byte            <= in_data.in_byte;
      s1_index           <= byte_index[AW-1:0];
    end
  end

  // left/upper-left exist once the index reaches bytes per pixel; the user must keep
  // bpp stable while beats are in flight (not enforced here), so it is evaluated in s1
  always_comb begin
    stage_ctrl         = s1_ctrl;
    stage_ctrl.left_ok = ({1'b0, s1_index} >= CW'(bpp_eff));
  end

  // Read at accept, write back at commit. A read of the address written by
  // the beat ahead needs a row start between them, so the two never meet.
  psu_row_mem #(
    .DEPTH (ROW_BYTES_MAX),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (data_fire),
    .rd_addr (byte_index[AW-1:0]),
    .rd_data (above_raw),
    .wr_en   (commit),
    .wr_addr (s1_index),
    .wr_data (result)
  );

  psu_recon #(
    .PIXEL_BYTES_MAX (PIXEL_BYTES_MAX),
    .AW              (AW),
    .PW              (PW)
  ) u_recon (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_ctrl   (stage_ctrl),
    .s1_byte   (s1_byte),
    .s1_index  (s1_index),
    .left_sel  (left_sel),
    .above_raw (above_raw),
    .take      (s1_take),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // input only stalls when s1 is full and the out register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a blocked output");

  // a row start always rewinds the position
  a_row_rewind: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.row_start) |=> (byte_index == '0))
    else $error("byte index not cleared by row start");

  // store read and write-back never hit the same entry on one edge
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (data_fire && commit) |-> (byte_index[AW-1:0] != s1_index))
    else $error("row store read and write collide");

  // an accepted data beat in range always lands in s1
  a_s1_load: assert property (@(posedge clk) disable iff (rst)
    data_fire |=> (s1_valid && s1_index == $past(byte_index[AW-1:0])))
    else $error("data beat lost on the way into s1");

endmodule

[test/testbench.sv]
// Self-checking testbench for png_scanline_unfilter: directed rows, register sweeps, random rows.
`timescale 1ns / 1ps

module testbench;
  import psu_pkg::*;

  localparam int ROW_BYTES_MAX   = 8192;
  localparam int PIXEL_BYTES_MAX = 8;
  localparam int DRAIN_CYCLES    = 4;     // drain margin after the last owed byte
  localparam int STALL_LIMIT     = 3000;  // cycles with no beat on any channel
  localparam int HOLD_CYCLES     = 150;
  localparam int REPORT_MAX      = 100;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  psu_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  psu_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [BPP_W-1:0] cfg_data = '0;

  png_scanline_unfilter #(
    .ROW_BYTES_MAX  (ROW_BYTES_MAX),
    .PIXEL_BYTES_MAX(PIXEL_BYTES_MAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Unfilter predictor state. Mirrors what the block should hold after each
  // accepted beat: the previous row, the per-row control, and the short
  // history of reconstructed bytes and their above terms, indexed by
  // position modulo PIXEL_BYTES_MAX.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] row_store [ROW_BYTES_MAX];
  logic [BYTE_W-1:0] last_raw [PIXEL_BYTES_MAX] = '{default: '0};
  logic [BYTE_W-1:0] last_above [PIXEL_BYTES_MAX] = '{default: '0};
  logic              above_is_zero = 1'b1;
  logic [FILT_W-1:0] row_filter = FILT_NONE;
  int unsigned       next_pos = 0;
  logic [BPP_W-1:0]  pixel_bytes = 4'd1;
  // Positions below this have been written since reset. Rows that reuse the
  // previous row (first_row clear) never run past it, so the store is never
  // read where it holds nothing.
  int                row_written_len = 0;

  psu_out_t raw_due [$];  // reconstructed bytes still owed by the block
  int       mismatch_count = 0;

  // Stimulus pacing, changed per phase
  int send_idle_pct = 22;
  int recv_idle_pct = 76;
  bit send_quiet = 1'b0;   // suppress sender gaps for a stretch
  int hold_request = 0;    // ask the receiver for a long hold-off
  int hold_left = 0;
  int quiet_left = 0;
  int stall_cycles = 0;

  function automatic logic [BYTE_W-1:0] paeth_guess(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [BYTE_W-1:0] c);
    int est, to_a, to_b, to_c;
    est  = int'(a) + int'(b) - int'(c);
    to_a = est - int'(a);
    to_b = est - int'(b);
    to_c = est - int'(c);
    if (to_a < 0) to_a = -to_a;
    if (to_b < 0) to_b = -to_b;
    if (to_c < 0) to_c = -to_c;
    // ties go to a, then b
    if (to_a <= to_b && to_a <= to_c) return a;
    if (to_b <= to_c) return b;
    return c;
  endfunction

  // Advance the predictor by one accepted beat; returns 1 with the expected
  // raw byte when the beat yields one.
  function automatic bit unfilter_beat(input psu_in_t beat, output psu_out_t raw);
    int unsigned       pos, span, back, slot;
    logic [BYTE_W-1:0] left, above, upleft, guess, value;
    logic [BYTE_W:0]   pair_sum;
    raw = '0;
    if (beat.row_start) begin
      // filter codes above Paeth decode as None
      row_filter    = (beat.in_byte <= FILT_PAETH) ? beat.in_byte[FILT_W-1:0] : FILT_NONE;
      above_is_zero = beat.first_row;
      next_pos      = 0;
      return 1'b0;
    end
    pos = next_pos;
    if (pos >= ROW_BYTES_MAX) return 1'b0;  // row overran the store: dropped
    span = (pixel_bytes == 0) ? 1 :
           (pixel_bytes > PIXEL_BYTES_MAX) ? PIXEL_BYTES_MAX : pixel_bytes;
    left   = '0;
    upleft = '0;
    above  = above_is_zero ? '0 : row_store[pos];
    if (pos >= span) begin
      back   = (pos - span) % PIXEL_BYTES_MAX;
      left   = last_raw[back];
      upleft = last_above[back];
    end
    case (row_filter)
      FILT_SUB: guess = left;
      FILT_UP:  guess = above;
      FILT_AVG: begin
        pair_sum = {1'b0, left} + {1'b0, above};
        guess    = pair_sum[BYTE_W:1];
      end
      FILT_PAETH: guess = paeth_guess(left, above, upleft);
      default:    guess = '0;
    endcase
    value            = beat.in_byte + guess;
    slot             = pos % PIXEL_BYTES_MAX;
    last_raw[slot]   = value;
    last_above[slot] = above;
    row_store[pos]   = value;
    if (int'(pos) + 1 > row_written_len) row_written_len = pos + 1;
    next_pos         = pos + 1;
    raw.out_byte     = value;
    raw.row_position = pos[POS_W-1:0];
    return 1'b1;
  endfunction

  function automatic psu_in_t mk_beat(input logic [BYTE_W-1:0] value, input logic start,
                                      input logic first);
    return {value, start, first};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < REPORT_MAX)
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driving side
  // ---------------------------------------------------------------------------

  // Offer one beat, hold it until taken, then update the predictor.
  task automatic send_beat(input psu_in_t beat);
    psu_out_t raw;
    while (!send_quiet && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (unfilter_beat(beat, raw)) raw_due.push_back(raw);
  endtask

  // Random data bytes; first_row is set now and then as noise (ignored).
  task automatic send_data(input int count);
    repeat (count)
      send_beat(mk_beat(8'($urandom_range(255)), 1'b0, $urandom_range(7) == 0));
  endtask

  task automatic send_row(input logic [BYTE_W-1:0] code, input bit first, input int len);
    send_beat(mk_beat(code, 1'b1, first));
    send_data(len);
  endtask

  task automatic send_row3(input logic [BYTE_W-1:0] code, input bit first,
                           input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                           input logic [BYTE_W-1:0] b2);
    send_beat(mk_beat(code, 1'b1, first));
    send_beat(mk_beat(b0, 1'b0, 1'b0));
    send_beat(mk_beat(b1, 1'b0, 1'b0));
    send_beat(mk_beat(b2, 1'b0, 1'b0));
  endtask

  // Stop offering, wait for every owed byte, then let a row start that is
  // still in flight settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (raw_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bpp(input logic [BPP_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    pixel_bytes = value;
  endtask

  // ---------------------------------------------------------------------------
  // Receiving side: random ready with quiet stretches and an on-demand long
  // hold-off; every out beat is checked against the oldest owed byte.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    psu_out_t want;
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (quiet_left != 0) begin
      quiet_left = quiet_left - 1;
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if ($urandom_range(63) == 0) quiet_left = 40;
    end

    if (!rst && out_valid && out_ready) begin
      if (raw_due.size() == 0) begin
        report_mismatch("out beat with nothing owed, out_byte", out_data.out_byte, -1);
      end else begin
        want = raw_due.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte at position %0d", want.row_position),
                          out_data.out_byte, want.out_byte);
        if (out_data.row_position !== want.row_position)
          report_mismatch("row_position", out_data.row_position, want.row_position);
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d bytes owed", stall_cycles,
               raw_due.size());
      $display("** png_scanline_unfilter: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset pixel width of 1: data before any row start, every filter, an
  // unknown filter code, byte extremes, first_row on data beats.
  task automatic test_directed();
    send_beat(mk_beat(8'hFF, 1'b0, 1'b1));
    send_beat(mk_beat(8'h00, 1'b0, 1'b0));
    send_beat(mk_beat(8'h80, 1'b0, 1'b1));
    send_row3(FILT_NONE, 1'b0, 8'h7F, 8'hFF, 8'h01);
    send_row3(FILT_SUB, 1'b1, 8'hFF, 8'h01, 8'h80);
    send_row3(FILT_UP, 1'b0, 8'h01, 8'hFF, 8'h00);
    send_row3(FILT_AVG, 1'b0, 8'hFF, 8'hFF, 8'h02);
    send_row3(FILT_PAETH, 1'b0, 8'h10, 8'hF0, 8'h55);
    send_row3(8'hFF, 1'b0, 8'hAA, 8'h55, 8'h00);
  endtask

  // A spread of widths, including 0 and out-of-range ones, and a width
  // change in the middle of a row.
  task automatic test_pixel_widths();
    logic [BPP_W-1:0] widths [10] = '{4'd0, 4'd15, 4'd8, 4'd2, 4'd3, 4'd5, 4'd9, 4'd4,
                                       4'd7, 4'd1};
    foreach (widths[k]) begin
      write_bpp(widths[k]);
      send_row(FILT_PAETH, k % 2 == 0, 18);
      send_row(k % 2 ? FILT_AVG : FILT_SUB, 1'b0, 18);
    end
    write_bpp(4'd3);
    send_row(FILT_PAETH, 1'b0, 10);
    write_bpp(4'd6);   // lands on the next data byte of the same row
    send_data(8);
    write_bpp(4'd1);
  endtask

  task automatic test_random_rows(input int beats);
    int               sent, len, pick;
    bit               first;
    logic [BYTE_W-1:0] code;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(11) == 0) write_bpp(4'($urandom_range(15)));
      pick  = $urandom_range(99);
      code  = (pick < 85) ? 8'($urandom_range(4)) : 8'($urandom_range(255, 5));
      first = (row_written_len == 0) || ($urandom_range(4) == 0);
      pick  = $urandom_range(99);
      if (pick < 4) len = 0;                       // back-to-back row starts
      else if (pick < 80) len = $urandom_range(24, 1);
      else if (pick < 96) len = $urandom_range(120, 25);
      else len = $urandom_range(400, 121);
      if (!first && len > row_written_len) len = row_written_len;
      send_quiet = ($urandom_range(3) == 0);
      send_row(code, first, len);
      sent += len + 1;
    end
    send_quiet = 1'b0;
  endtask

  // Receiver stalls long enough for the block to fill and drop in_ready;
  // then the sender waits for every owed byte before going on.
  task automatic test_backpressure();
    send_quiet   = 1'b1;
    hold_request = HOLD_CYCLES;
    send_row(FILT_PAETH, 1'b1, 60);
    wait_drained();
    send_row(FILT_UP, 1'b0, 30);
    send_quiet = 1'b0;
  endtask

  // Longer rows at the widest pixel, the second reading back most of the
  // first, then a narrow width.
  task automatic test_long_row();
    write_bpp(4'd8);
    send_row(FILT_SUB, 1'b1, 200);
    send_row(FILT_PAETH, 1'b0, 160);
    write_bpp(4'd2);
    send_row(FILT_AVG, 1'b0, 40);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender sparse gaps, receiver mostly stalled
    send_idle_pct = 22;
    recv_idle_pct = 76;
    test_directed();
    test_pixel_widths();
    test_random_rows(160);
    test_backpressure();

    // swapped
    send_idle_pct = 76;
    recv_idle_pct = 22;
    test_random_rows(160);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_rows(160);
    test_long_row();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && raw_due.size() == 0) begin
      $display("** png_scanline_unfilter: PASSED **");
    end else begin
      $display("** png_scanline_unfilter: FAILED **");
    end
    $finish;
  end

endmodule

[png_scanline_unfilter.f]
hw/rtl/psu_pkg.sv
hw/rtl/psu_row_mem.sv
hw/rtl/psu_recon.sv
hw/rtl/png_scanline_unfilter.sv
test/testbench.sv
